>>> hw/rtl/bsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants
// Widths, action and status codes for the safety allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;
   localparam int CUSTOMERS   = 8;
   localparam int RESOURCES   = 4;
   localparam int COUNT_WIDTH = 8;
   localparam int CUST_WIDTH  = $clog2(CUSTOMERS);
   localparam int CUST_CNT_W  = $clog2(CUSTOMERS + 1);
   localparam int AMOUNT_WIDTH = 8;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef count_type [RESOURCES-1:0] vec_type;
   // pool may exceed count range during the scan
   typedef logic [COUNT_WIDTH+CUST_WIDTH:0] pool_elem_type;
   typedef pool_elem_type [RESOURCES-1:0] pool_type;

   localparam logic [1:0] ACT_REQUEST = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_DEFINE  = 2'd2;
   localparam logic [1:0] ACT_SETAVL  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVER_NEED = 2'd1;
   localparam logic [1:0] ST_OVER_AVL  = 2'd2;
   localparam logic [1:0] ST_UNSAFE    = 2'd3;

   // saturate an 8-bit amount into a count
   function automatic count_type sat_amount(input logic [AMOUNT_WIDTH-1:0] a);
      logic [AMOUNT_WIDTH+COUNT_WIDTH-1:0] w;
      w = {{COUNT_WIDTH{1'b0}}, a};
      if (w > {{AMOUNT_WIDTH{1'b0}}, COUNT_MAX}) return COUNT_MAX;
      return w[COUNT_WIDTH-1:0];
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/bsa_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_lane: per-resource compare lane
// Tests one customer's need of one resource against the working pool.
// ----------------------------------------------------------------------------
module bsa_lane
   import bsa_pkg::*;
(
   input  wire count_type     need,
   input  wire pool_elem_type pool,
   output logic               fits
);
   // need fits in pool
   assign fits = ({{(CUST_WIDTH+1){1'b0}}, need} <= pool);
endmodule
`default_nettype wire

>>> hw/rtl/bankers_safety_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bankers_safety_allocator_unit: banker's algorithm allocator
// Request / release / define / set-available with a safety scan.
// ----------------------------------------------------------------------------
// channel   ports                       handshake
// request   req_action..req_amount_3    start & !busy
// response  rsp_status, rsp_avail_0..3  rsp_valid, one cycle
//
// Set-up, release and refused requests go from EXEC to DONE, then answer.
// A granted request runs the safety scan: one customer tested per cycle,
// resources in parallel lanes, restart at customer 0 after each finish;
// the scan ends when the last customer does not fit, rolling back if unsafe,
// and the answer follows through DONE. Busy stays high through the answer.
// Reset clears all counts. The receiver cannot stall.
module bankers_safety_allocator_unit
   import bsa_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   output logic       busy,
   input  wire  [1:0] req_action,
   input  wire  [2:0] req_customer,
   input  wire  [7:0] req_amount_0,
   input  wire  [7:0] req_amount_1,
   input  wire  [7:0] req_amount_2,
   input  wire  [7:0] req_amount_3,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_avail_0,
   output logic [7:0] rsp_avail_1,
   output logic [7:0] rsp_avail_2,
   output logic [7:0] rsp_avail_3
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   vec_type avail_ff, avail_in;
   vec_type alloc_ff [CUSTOMERS];
   vec_type need_ff  [CUSTOMERS];
   vec_type alloc_in [CUSTOMERS];
   vec_type need_in  [CUSTOMERS];
   logic [1:0] act_ff, act_in;
   logic [2:0] cust_ff, cust_in;
   vec_type amt_ff, amt_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   pool_type pool_ff, pool_in;
   logic [CUSTOMERS-1:0] done_ff, done_in;
   logic [CUST_WIDTH-1:0] scan_ff, scan_in;
   logic [AMOUNT_WIDTH-1:0] raw_amt [4];

   logic [RESOURCES-1:0] lane_fit;
   logic scan_fit;

   assign raw_amt[0] = req_amount_0;
   assign raw_amt[1] = req_amount_1;
   assign raw_amt[2] = req_amount_2;
   assign raw_amt[3] = req_amount_3;

   // compare lanes for the scanned customer
   for (genvar r = 0; r < RESOURCES; r++) begin : g_lane
      bsa_lane u_lane (
         .need (need_ff[scan_ff][r]),
         .pool (pool_ff[r]),
         .fits (lane_fit[r])
      );
   end

   // merge lane results
   assign scan_fit = (&lane_fit) && !done_ff[scan_ff];

   logic cust_ok;
   logic [CUST_WIDTH-1:0] ci;
   assign cust_ok = ({1'b0, cust_ff} < 4'(CUSTOMERS));
   assign ci = cust_ff[CUST_WIDTH-1:0];

   // next-state logic
   always_comb begin
      logic [COUNT_WIDTH:0] s;
      count_type back;
      logic refused;
      s = '0;
      back = '0;
      state_in = state_ff;
      avail_in = avail_ff;
      alloc_in = alloc_ff;
      need_in = need_ff;
      act_in = act_ff;
      cust_in = cust_ff;
      amt_in = amt_ff;
      status_in = status_ff;
      rsp_valid_in = 1'b0;
      pool_in = pool_ff;
      done_in = done_ff;
      scan_in = scan_ff;
      refused = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               act_in = req_action;
               cust_in = req_customer;
               for (int r = 0; r < RESOURCES; r++) amt_in[r] = sat_amount(raw_amt[r]);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            state_in = S_DONE;
            if (act_ff == ACT_SETAVL) begin
               avail_in = amt_ff;
            end else if (cust_ok) begin
               case (act_ff)
                  ACT_REQUEST: begin
                     for (int r = RESOURCES - 1; r >= 0; r--) begin
                        if (amt_ff[r] > need_ff[ci][r]) begin
                           status_in = ST_OVER_NEED; refused = 1'b1;
                        end else if (amt_ff[r] > avail_ff[r]) begin
                           status_in = ST_OVER_AVL; refused = 1'b1;
                        end
                     end
                     if (!refused) begin
                        for (int r = 0; r < RESOURCES; r++) begin
                           avail_in[r] = avail_ff[r] - amt_ff[r];
                           need_in[ci][r] = need_ff[ci][r] - amt_ff[r];
                           alloc_in[ci][r] = alloc_ff[ci][r] + amt_ff[r];
                           pool_in[r] = pool_elem_type'(avail_in[r]);
                        end
                        done_in = '0;
                        scan_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  ACT_RELEASE: begin
                     for (int r = 0; r < RESOURCES; r++) begin
                        back = (amt_ff[r] < alloc_ff[ci][r]) ? amt_ff[r] : alloc_ff[ci][r];
                        s = {1'b0, avail_ff[r]} + {1'b0, back};
                        avail_in[r] = s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
                        s = {1'b0, need_ff[ci][r]} + {1'b0, back};
                        need_in[ci][r] = s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
                        alloc_in[ci][r] = alloc_ff[ci][r] - back;
                     end
                  end
                  default: begin
                     for (int r = 0; r < RESOURCES; r++) begin
                        alloc_in[ci][r] = '0;
                        need_in[ci][r] = (amt_ff[r] < avail_ff[r]) ? amt_ff[r] : avail_ff[r];
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_fit) begin
               for (int r = 0; r < RESOURCES; r++)
                  pool_in[r] = pool_ff[r] + pool_elem_type'(alloc_ff[scan_ff][r]);
               done_in[scan_ff] = 1'b1;
               scan_in = '0;
            end else if (scan_ff == CUST_WIDTH'(CUSTOMERS - 1)) begin
               state_in = S_DONE;
               if (&done_ff) begin
                  status_in = ST_OK;
               end else begin
                  // roll the grant back: the full amount is still allocated
                  status_in = ST_UNSAFE;
                  for (int r = 0; r < RESOURCES; r++) begin
                     s = {1'b0, avail_ff[r]} + {1'b0, amt_ff[r]};
                     avail_in[r] = s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
                     s = {1'b0, need_ff[ci][r]} + {1'b0, amt_ff[r]};
                     need_in[ci][r] = s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
                     alloc_in[ci][r] = alloc_ff[ci][r] - amt_ff[r];
                  end
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         avail_ff <= '0;
         for (int c = 0; c < CUSTOMERS; c++) begin
            alloc_ff[c] <= '0;
            need_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         avail_ff <= avail_in;
         alloc_ff <= alloc_in;
         need_ff <= need_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      act_ff <= act_in;
      cust_ff <= cust_in;
      amt_ff <= amt_in;
      status_ff <= status_in;
      pool_ff <= pool_in;
      done_ff <= done_in;
      scan_ff <= scan_in;
   end

   assign busy = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_avail_0 = avail_ff[0];
   assign rsp_avail_1 = avail_ff[1];
   assign rsp_avail_2 = avail_ff[2];
   assign rsp_avail_3 = avail_ff[3];
endmodule
`default_nettype wire

>>> hw/rtl/bsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_checker: port-level checks
// Watches the command and response ports of the allocator.
// ----------------------------------------------------------------------------
module bsa_checker
   import bsa_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       start,
   input wire       busy,
   input wire       rsp_valid,
   input wire [1:0] rsp_status
);
   // an accepted word makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after start");

   // response is a single-cycle strobe
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response held");

   // nothing answers without a word in flight
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");

   // idle after a response
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after response");

   // status is defined whenever a response is shown
   a_status_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_status)) else $error("unknown status");
endmodule

bind bankers_safety_allocator_unit bsa_checker u_bsa_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status)
);
`default_nettype wire
